>>> design/lnbt_pkg.sv
// Shared codes, constants and types for the batch trainer.
package lnbt_pkg;

  localparam logic [1:0] OP_TRAIN   = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] REG_LEARN_RATE = 3'd0;
  localparam logic [2:0] REG_BATCH_SIZE = 3'd1;
  localparam logic [2:0] REG_INIT_W1    = 3'd2;
  localparam logic [2:0] REG_INIT_W2    = 3'd3;
  localparam logic [2:0] REG_INIT_BIAS  = 3'd4;

  // One in Q30, the working format of the sigmoid table series.
  localparam longint unsigned SIG_Q30_ONE = 64'd1 << 30;

  // Control and status between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

>>> design/lnbt_div.sv
// Radix-2 restoring divider: signed dividend over an unsigned count, truncated toward zero.
module lnbt_div
  import lnbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] dividend_i,
  input  logic [9:0]         divisor_i,
  output logic signed [47:0] quotient_o,
  output div_ctl_t           status_o
);

  logic [47:0] rem_q, rem_d, quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [9:0]  den_q, den_d;
  logic [48:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      neg_d  = dividend_i[47];
      quo_d  = dividend_i[47] ? 48'(-dividend_i) : dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[47]} - {39'd0, den_q};
      if (!trial[48]) begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[46:0], quo_q[47]};
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    den_q <= den_d;
  end

  assign quotient_o      = neg_q ? 48'(-quo_q) : quo_q;
  assign status_o.start  = start_i;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

>>> design/logistic_neuron_batch_trainer_unit.sv
// Top level of the two-input sigmoid neuron trainer with batch gradient descent.
// Restart and unknown codes go straight to the result; predict runs the multiply steps
// and the table lookup; train adds the gradient and accumulate steps; a train item that
// closes a batch adds three divide-and-step passes on the serial divider and the shared
// 33x33 multiplier. One item at a time; the next may enter in the cycle its result appears.
// Reset clears weights, sums, count and control, and loads rate 10.0, batch 4, zero weights.
module logistic_neuron_batch_trainer_unit
  import lnbt_pkg::*;
#(
  parameter int BATCH_MAX           = 256,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] x_one_i,
  input  logic signed [15:0] x_two_i,
  input  logic [12:0]        target_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        activation_o,
  output logic signed [31:0] weight_one_o,
  output logic signed [31:0] weight_two_o,
  output logic signed [31:0] bias_out_o,
  output logic               batch_done_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int IdxW = $clog2(SIGMOID_TABLE_DEPTH);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_LOOK  = 4'd3;
  localparam logic [3:0] S_G     = 4'd4;
  localparam logic [3:0] S_DELTA = 4'd5;
  localparam logic [3:0] S_ACC1  = 4'd6;
  localparam logic [3:0] S_ACC2  = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_STEP  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  // Sigmoid table, built at elaboration. Each entry is the sigmoid at the center of
  // its bin: e^(-|z|/16) comes from a 16-term series in Q30, four squarings raise
  // it to e^(-|z|), and the final quotient is rounded to nearest.
  logic [15:0] sig_rom [SIGMOID_TABLE_DEPTH];
  for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned TwoK = 64'(2 * k + 1);
    localparam bit Pos = (TwoK > 64'(SIGMOID_TABLE_DEPTH));
    localparam longint unsigned Mag = Pos ? TwoK - 64'(SIGMOID_TABLE_DEPTH) :
                                            64'(SIGMOID_TABLE_DEPTH) - TwoK;
    localparam longint unsigned U   = (Mag << 30) / (64'(SIGMOID_TABLE_DEPTH) * 64'd2);
    localparam longint unsigned T1  = (SIG_Q30_ONE * U) / (64'd1 << 30);
    localparam longint unsigned T2  = (T1 * U) / (64'd2 << 30);
    localparam longint unsigned T3  = (T2 * U) / (64'd3 << 30);
    localparam longint unsigned T4  = (T3 * U) / (64'd4 << 30);
    localparam longint unsigned T5  = (T4 * U) / (64'd5 << 30);
    localparam longint unsigned T6  = (T5 * U) / (64'd6 << 30);
    localparam longint unsigned T7  = (T6 * U) / (64'd7 << 30);
    localparam longint unsigned T8  = (T7 * U) / (64'd8 << 30);
    localparam longint unsigned T9  = (T8 * U) / (64'd9 << 30);
    localparam longint unsigned T10 = (T9 * U) / (64'd10 << 30);
    localparam longint unsigned T11 = (T10 * U) / (64'd11 << 30);
    localparam longint unsigned T12 = (T11 * U) / (64'd12 << 30);
    localparam longint unsigned T13 = (T12 * U) / (64'd13 << 30);
    localparam longint unsigned T14 = (T13 * U) / (64'd14 << 30);
    localparam longint unsigned T15 = (T14 * U) / (64'd15 << 30);
    localparam longint unsigned T16 = (T15 * U) / (64'd16 << 30);
    localparam longint unsigned E0  = SIG_Q30_ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8
                                      - T9 + T10 - T11 + T12 - T13 + T14 - T15 + T16;
    localparam longint unsigned E1  = (E0 * E0 + (SIG_Q30_ONE >> 1)) >> 30;
    localparam longint unsigned E2  = (E1 * E1 + (SIG_Q30_ONE >> 1)) >> 30;
    localparam longint unsigned E3  = (E2 * E2 + (SIG_Q30_ONE >> 1)) >> 30;
    localparam longint unsigned E4  = (E3 * E3 + (SIG_Q30_ONE >> 1)) >> 30;
    localparam longint unsigned Den = SIG_Q30_ONE + E4;
    localparam longint unsigned Num = Pos ? (SIG_Q30_ONE << 16) : (E4 << 16);
    localparam longint unsigned Sig = (Num + (Den >> 1)) / Den;
    assign sig_rom[k] = (Sig > 64'd65535) ? 16'hffff : 16'(Sig);
  end

  logic [15:0] rate_q;
  logic [8:0]  bsize_q;
  logic signed [31:0] iw1_q, iw2_q, ib_q;

  logic [3:0]  state_q, state_d;
  logic signed [31:0] w1_q, w2_q, b_q;
  logic signed [47:0] s1_q, s2_q, sb_q;
  logic [8:0]  cnt_q;
  logic [1:0]  op_q;
  logic signed [15:0] x1_q, x2_q;
  logic [12:0] tgt_q;
  logic signed [63:0] acc_q;      // z accumulator, then scratch product
  logic signed [31:0] delta_q;
  logic [15:0] act_q;
  logic        done_q;
  logic [1:0]  sel_q;             // which weight the update is working on
  logic signed [47:0] mean_q;
  logic        out_v_q;

  // The one shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [63:0] z_full;
  logic [IdxW-1:0]    rom_idx;
  logic signed [63:0] z_off;
  logic [12:0] tgt_c;
  logic [9:0]  eff_size;
  logic [9:0]  div_den;
  logic        div_start;
  logic signed [47:0] div_quo;
  div_ctl_t    div_st;
  logic signed [31:0] cur_w;
  logic signed [63:0] step_v;
  logic signed [63:0] new_w;
  logic signed [31:0] new_w_sat;
  logic        in_xfer;
  logic        out_load;

  assign z_full = (acc_q >>> 12) + 64'(b_q);
  assign z_off  = z_full + 64'sd524288;
  assign rom_idx = IdxW'((z_off * SIGMOID_TABLE_DEPTH) >>> 20);
  assign tgt_c  = (tgt_q > 13'd4096) ? 13'd4096 : tgt_q;

  always_comb begin
    if (bsize_q == 9'd0) eff_size = 10'd1;
    else if (32'(bsize_q) > BATCH_MAX) eff_size = 10'(BATCH_MAX);
    else eff_size = {1'b0, bsize_q};
  end

  assign div_den = (cnt_q == 9'd0) ? 10'd512 : {1'b0, cnt_q};

  always_comb begin
    unique case (sel_q)
      2'd0:    cur_w = w1_q;
      2'd1:    cur_w = w2_q;
      default: cur_w = b_q;
    endcase
  end

  // Operand selection per sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL1:  begin mul_a = 33'(w1_q); mul_b = 33'(x1_q); end
      S_MUL2:  begin mul_a = 33'(w2_q); mul_b = 33'(x2_q); end
      S_G:     begin mul_a = 33'({1'b0, act_q}); mul_b = 33'(17'd65536 - {1'b0, act_q}); end
      S_DELTA: begin
        mul_a = 33'(32'sd2 * ($signed({16'd0, act_q}) - $signed({15'd0, tgt_c, 4'd0})));
        mul_b = 33'(acc_q[31:0]);
      end
      S_ACC1:  begin mul_a = 33'(delta_q); mul_b = 33'(x1_q); end
      S_ACC2:  begin mul_a = 33'(delta_q); mul_b = 33'(x2_q); end
      S_STEP:  begin mul_a = 33'({1'b0, rate_q}); mul_b = 33'(mean_q[32:0]); end
      default: ;
    endcase
  end

  // The mean stays well inside 33 bits: |delta| <= 2^15 and |x| <= 2^15.
  assign step_v = 64'(mul_p) >>> 20;
  assign new_w  = 64'(cur_w) - step_v;
  assign new_w_sat = (new_w > 64'sd2147483647) ? 32'sh7fffffff :
                     (new_w < -64'sd2147483648) ? 32'sh80000000 : new_w[31:0];

  assign div_start = (state_q == S_CHECK) || (state_q == S_STEP && sel_q != 2'd2);

  lnbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start && (state_q == S_CHECK ? ({1'b0, cnt_q} == 10'd0 ||
                 {1'b0, cnt_q} >= eff_size) : 1'b1)),
    .dividend_i (state_q == S_CHECK ? s1_q : (sel_q == 2'd0 ? s2_q : sb_q)),
    .divisor_i  (div_den),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  // The result sits in its own output register, so the sequencer is free again as
  // soon as the result is loaded; it only waits in the output step when an earlier
  // result is still held by a stalled receiver.
  assign in_stall  = (state_q != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_load  = (state_q == S_OUT) && !(out_v_q && out_stall);
  assign cfg_ready = (state_q == S_IDLE) && !out_v_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid) begin
        state_d = (operation_i == OP_TRAIN || operation_i == OP_PREDICT) ? S_MUL1 : S_OUT;
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_LOOK;
      S_LOOK:  state_d = (op_q == OP_TRAIN) ? S_G : S_OUT;
      S_G:     state_d = S_DELTA;
      S_DELTA: state_d = S_ACC1;
      S_ACC1:  state_d = S_ACC2;
      S_ACC2:  state_d = S_CHECK;
      S_CHECK: state_d = (cnt_q == 9'd0 || {1'b0, cnt_q} >= eff_size) ? S_DIV : S_OUT;
      S_DIV:   if (div_st.done) state_d = S_STEP;
      S_STEP:  state_d = (sel_q == 2'd2) ? S_OUT : S_DIV;
      S_OUT:   state_d = out_load ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      rate_q  <= 16'd2560;
      bsize_q <= 9'd4;
      iw1_q   <= '0;
      iw2_q   <= '0;
      ib_q    <= '0;
      w1_q    <= '0;
      w2_q    <= '0;
      b_q     <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
      sb_q    <= '0;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_v_q <= 1'b1;
      else if (!out_stall) out_v_q <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_i)
          REG_LEARN_RATE: rate_q  <= cfg_data_i[15:0];
          REG_BATCH_SIZE: bsize_q <= cfg_data_i[8:0];
          REG_INIT_W1:    iw1_q   <= cfg_data_i;
          REG_INIT_W2:    iw2_q   <= cfg_data_i;
          REG_INIT_BIAS:  ib_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer && operation_i == OP_RESTART) begin
        w1_q  <= iw1_q;
        w2_q  <= iw2_q;
        b_q   <= ib_q;
        s1_q  <= '0;
        s2_q  <= '0;
        sb_q  <= '0;
        cnt_q <= '0;
      end
      if (state_q == S_DELTA) begin
        // The bias sum gains delta * 2^12 directly.
        sb_q  <= sb_q + 48'(64'(mul_p) >>> 16 <<< 12);
        cnt_q <= cnt_q + 9'd1;
      end
      if (state_q == S_ACC1) s1_q <= s1_q + 48'(mul_p);
      if (state_q == S_ACC2) s2_q <= s2_q + 48'(mul_p);
      if (state_q == S_CHECK) sel_q <= 2'd0;
      if (state_q == S_STEP) begin
        unique case (sel_q)
          2'd0:    w1_q <= new_w_sat;
          2'd1:    w2_q <= new_w_sat;
          default: begin
            b_q   <= new_w_sat;
            s1_q  <= '0;
            s2_q  <= '0;
            sb_q  <= '0;
            cnt_q <= '0;
          end
        endcase
        sel_q <= sel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= operation_i;
      x1_q   <= x_one_i;
      x2_q   <= x_two_i;
      tgt_q  <= target_i;
      act_q  <= '0;
      done_q <= 1'b0;
    end
    if (state_q == S_MUL1) acc_q <= 64'(mul_p);
    if (state_q == S_MUL2) acc_q <= acc_q + 64'(mul_p);
    if (state_q == S_LOOK) begin
      if (z_full < -64'sd524288) act_q <= 16'd0;
      else if (z_full >= 64'sd524288) act_q <= 16'hffff;
      else act_q <= sig_rom[rom_idx];
    end
    if (state_q == S_G) acc_q <= 64'(mul_p) >>> 16;
    if (state_q == S_DELTA) delta_q <= 32'(64'(mul_p) >>> 16);
    if (state_q == S_CHECK && (cnt_q == 9'd0 || {1'b0, cnt_q} >= eff_size)) done_q <= 1'b1;
    if (div_st.done) mean_q <= div_quo;
    if (out_load) begin
      activation_o <= act_q;
      weight_one_o <= w1_q;
      weight_two_o <= w2_q;
      bias_out_o   <= b_q;
      batch_done_o <= done_q;
    end
  end

  assign out_valid = out_v_q;

`ifndef SYNTHESIS
  // A result held by the receiver keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(activation_o) &&
      $stable(weight_one_o) && $stable(weight_two_o) && $stable(bias_out_o) &&
      $stable(batch_done_o))
    else $error("stalled result changed");
  // A result appears only from the output step.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q) == S_OUT)
    else $error("result without output step");
  // The divider only runs during the update.
  a_div_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == S_DIV || state_q == S_STEP))
    else $error("divider busy outside update");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the two-input sigmoid neuron batch trainer.
`timescale 1ns / 100ps

module tb;
  import lnbt_pkg::*;

  // Operation code 3 is not assigned; the block must leave its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ROM_DEPTH = 256;
  localparam int CAP_BATCH = 256;

  typedef struct packed {
    logic [15:0]        act;
    logic signed [31:0] w1;
    logic signed [31:0] w2;
    logic signed [31:0] b;
    logic               done;
  } neuron_result_t;

  // One row of the directed stimulus. When fixed_res is set, the row carries
  // an expectation typed in by hand instead of the one the predictor computes.
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic [12:0]        tgt;
    bit                 fixed_res;
    neuron_result_t     res;
  } sample_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation_i = OP_PREDICT;
  logic signed [15:0] x_one_i = '0;
  logic signed [15:0] x_two_i = '0;
  logic [12:0]        target_i = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        activation_o;
  logic signed [31:0] weight_one_o;
  logic signed [31:0] weight_two_o;
  logic signed [31:0] bias_out_o;
  logic               batch_done_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index_i = REG_LEARN_RATE;
  logic [31:0]        cfg_data_i = '0;

  logistic_neuron_batch_trainer_unit dut (.*);

  always #10 clk_i = ~clk_i;

  // Shadow copy of the trainer: registers, weights, gradient sums and count.
  logic [15:0]        sh_rate;
  logic [8:0]         sh_batch;
  logic signed [31:0] sh_init_w1, sh_init_w2, sh_init_b;
  logic signed [31:0] sh_w1, sh_w2, sh_b;
  longint             sh_sum1, sh_sum2, sh_sumb;
  logic [8:0]         sh_count;
  logic [15:0]        sig_table [ROM_DEPTH];

  neuron_result_t pending_results[$];
  sample_row_t    directed_rows[$];
  int             fail_count = 0;
  int             burst_left = 0;

  // e^(-u) in Q30 by a 16-term series, valid for small u.
  function automatic longint unsigned exp_neg_q30(longint unsigned u);
    longint          sum;
    longint unsigned term;
    sum  = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = (term * u) / (longint'(n) << 30);
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return longint'(sum);
  endfunction

  // Fill the sigmoid table: the bin center is evaluated as e^(-|z|/16) raised
  // to the 16th power by four squarings.
  function automatic void fill_sigmoid_table();
    longint unsigned twok, m, u, e, den, s;
    bit              pos;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      twok = 2 * k + 1;
      pos  = twok > ROM_DEPTH;
      m    = pos ? twok - ROM_DEPTH : ROM_DEPTH - twok;
      u    = (m << 30) / (2 * ROM_DEPTH);
      e    = exp_neg_q30(u);
      for (int i = 0; i < 4; i++) e = (e * e + (64'd1 << 29)) >> 30;
      den = (64'd1 << 30) + e;
      if (pos) s = ((64'd1 << 46) + den / 2) / den;
      else s = ((e << 16) + den / 2) / den;
      if (s > 65535) s = 65535;
      sig_table[k] = s[15:0];
    end
  endfunction

  function automatic logic [15:0] sigmoid_of(longint z);
    longint off, idx;
    if (z < -(64'sd8 <<< 16)) return 16'd0;
    if (z >= (64'sd8 <<< 16)) return 16'hFFFF;
    off = z + (64'sd8 <<< 16);
    idx = (off * ROM_DEPTH) >>> 20;
    if (idx >= ROM_DEPTH) idx = ROM_DEPTH - 1;
    return sig_table[idx];
  endfunction

  // Weight minus rate times the batch mean, saturated to 32 bits.
  function automatic logic signed [31:0] stepped_weight(logic signed [31:0] w, longint sum,
                                                        longint cnt);
    longint mean, step, r;
    mean = sum / cnt;
    step = (longint'({48'd0, sh_rate}) * mean) >>> 20;
    r = longint'(w) - step;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic neuron_result_t train_step(logic [1:0] op, logic signed [15:0] x1,
                                                 logic signed [15:0] x2, logic [12:0] tgt);
    neuron_result_t res;
    longint         z, a, lbl, g, delta, eff, cnt;
    res = '0;
    if (op == OP_TRAIN || op == OP_PREDICT) begin
      z = ((longint'(sh_w1) * longint'(x1) + longint'(sh_w2) * longint'(x2)) >>> 12)
          + longint'(sh_b);
      res.act = sigmoid_of(z);
    end
    if (op == OP_TRAIN) begin
      a     = longint'({48'd0, res.act});
      lbl   = (tgt > 13'd4096) ? 64'sd4096 * 16 : longint'({51'd0, tgt}) * 16;
      g     = (a * (65536 - a)) >>> 16;
      delta = (2 * (a - lbl) * g) >>> 16;
      sh_sum1 += delta * longint'(x1);
      sh_sum2 += delta * longint'(x2);
      sh_sumb += delta * 4096;
      sh_count = sh_count + 9'd1;
      eff = (sh_batch == 0) ? 1 : longint'({55'd0, sh_batch});
      if (eff > CAP_BATCH) eff = CAP_BATCH;
      if (sh_count == 0 || longint'({55'd0, sh_count}) >= eff) begin
        cnt = (sh_count == 0) ? 512 : longint'({55'd0, sh_count});
        sh_w1 = stepped_weight(sh_w1, sh_sum1, cnt);
        sh_w2 = stepped_weight(sh_w2, sh_sum2, cnt);
        sh_b  = stepped_weight(sh_b, sh_sumb, cnt);
        sh_sum1 = 0;
        sh_sum2 = 0;
        sh_sumb = 0;
        sh_count = '0;
        res.done = 1'b1;
      end
    end else if (op == OP_RESTART) begin
      sh_w1 = sh_init_w1;
      sh_w2 = sh_init_w2;
      sh_b  = sh_init_b;
      sh_sum1 = 0;
      sh_sum2 = 0;
      sh_sumb = 0;
      sh_count = '0;
    end
    res.w1 = sh_w1;
    res.w2 = sh_w2;
    res.b  = sh_b;
    return res;
  endfunction

  task automatic add_row(logic [1:0] op, logic signed [15:0] x1, logic signed [15:0] x2,
                         logic [12:0] tgt, bit fixed_res = 1'b0,
                         neuron_result_t res = '0);
    sample_row_t r;
    r.op = op;
    r.x1 = x1;
    r.x2 = x2;
    r.tgt = tgt;
    r.fixed_res = fixed_res;
    r.res = res;
    directed_rows.push_back(r);
  endtask

  // Offer one sample and hold it until the block takes the transfer. The
  // sender works in bursts; between bursts valid may drop for a random gap.
  task automatic send_sample(logic [1:0] op, logic signed [15:0] x1, logic signed [15:0] x2,
                             logic [12:0] tgt, bit fixed_res = 1'b0,
                             neuron_result_t res = '0);
    neuron_result_t predicted;
    int             gap;
    @(negedge clk_i);
    operation_i <= op;
    x_one_i <= x1;
    x_two_i <= x2;
    target_i <= tgt;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    predicted = train_step(op, x1, x2, tgt);
    pending_results.push_back(fixed_res ? res : predicted);
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_LEARN_RATE: sh_rate = data[15:0];
      REG_BATCH_SIZE: sh_batch = data[8:0];
      REG_INIT_W1:    sh_init_w1 = data;
      REG_INIT_W2:    sh_init_w2 = data;
      REG_INIT_BIAS:  sh_init_b = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with the pipeline empty.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_feature();
    case ($urandom_range(3, 0))
      0: return 16'($urandom);
      1: return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
      default: return 16'(int'($urandom_range(8192, 0)) - 4096);
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99, 0);
    if (r < 80) return OP_TRAIN;
    if (r < 91) return OP_PREDICT;
    if (r < 97) return OP_RESTART;
    return OP_UNUSED;
  endfunction

  initial begin
    logic [31:0] rates[6]   = '{32'd65535, 32'd0, 32'd1000, 32'd300, 32'd4000, 32'd2560};
    logic [31:0] batches[6] = '{32'd1, 32'd0, 32'd256, 32'd511, 32'd3, 32'd8};
    int          counts[6]  = '{100, 80, 300, 120, 150, 100};
    fill_sigmoid_table();
    sh_rate = 16'd2560;
    sh_batch = 9'd4;
    sh_init_w1 = '0;
    sh_init_w2 = '0;
    sh_init_b = '0;
    sh_w1 = '0;
    sh_w2 = '0;
    sh_b = '0;
    sh_sum1 = 0;
    sh_sum2 = 0;
    sh_sumb = 0;
    sh_count = '0;

    // Directed part: reset state, operand extremes, every operation, the
    // target clamp, and a batch left half full for the batch-size change below.
    add_row(OP_PREDICT, 16'sd0, 16'sd0, 13'd0);
    add_row(OP_RESTART, 16'sh7FFF, 16'sh8000, 13'd4096, 1'b1, '0);
    add_row(OP_UNUSED, 16'sh7FFF, 16'sh7FFF, 13'h1FFF, 1'b1, '0);
    add_row(OP_PREDICT, 16'sh7FFF, 16'sh8000, 13'd0);
    add_row(OP_TRAIN, 16'sh7FFF, 16'sh7FFF, 13'd4096);
    add_row(OP_TRAIN, 16'sh8000, 16'sh8000, 13'd0);
    add_row(OP_TRAIN, 16'sd0, 16'sd0, 13'h1FFF);
    add_row(OP_TRAIN, 16'sd1234, -16'sd1, 13'd4096);
    add_row(OP_PREDICT, 16'sh8000, 16'sh7FFF, 13'd0);
    add_row(OP_TRAIN, 16'sd4096, -16'sd4096, 13'd0);
    add_row(OP_TRAIN, -16'sd4096, 16'sd4096, 13'd4097);
    add_row(OP_TRAIN, 16'sd2048, 16'sd2048, 13'd2048);
    add_row(OP_TRAIN, 16'sh7FFF, 16'sd0, 13'd4096);
    add_row(OP_UNUSED, 16'sd0, 16'sd0, 13'd0);
    add_row(OP_RESTART, 16'sd0, 16'sd0, 13'd0, 1'b1, '0);
    add_row(OP_TRAIN, 16'sd100, 16'sd200, 13'd1000);
    add_row(OP_TRAIN, -16'sd300, 16'sd50, 13'd3000);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].op, directed_rows[i].x1, directed_rows[i].x2,
                  directed_rows[i].tgt, directed_rows[i].fixed_res, directed_rows[i].res);

    // Random phases, each under its own register setting. The first one lowers
    // the batch size while two samples are still pending.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(REG_LEARN_RATE, rates[p]);
      write_reg(REG_BATCH_SIZE, batches[p]);
      case (p)
        0: begin
          write_reg(REG_INIT_W1, 32'h7FFF_FFFF);
          write_reg(REG_INIT_W2, 32'h8000_0000);
          write_reg(REG_INIT_BIAS, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(REG_INIT_W1, 32'h8000_0000);
          write_reg(REG_INIT_W2, 32'h7FFF_FFFF);
          write_reg(REG_INIT_BIAS, 32'h8000_0000);
        end
        default: begin
          write_reg(REG_INIT_W1, 32'(int'($urandom_range(262144, 0)) - 131072));
          write_reg(REG_INIT_W2, 32'(int'($urandom_range(262144, 0)) - 131072));
          write_reg(REG_INIT_BIAS, $urandom);
        end
      endcase
      for (int n = 0; n < counts[p]; n++) begin
        logic [12:0] tgt;
        tgt = ($urandom_range(9, 0) == 0) ? 13'($urandom) : 13'($urandom_range(4096, 0));
        send_sample(pick_op(), pick_feature(), pick_feature(), tgt);
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: a stall pattern picked at random among no stall, random stall and a regular
  // stall, plus one long hold-off so the block backs up and stalls its input.
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(2, 0);
      if (cyc >= 4000 && cyc < 4600) out_stall <= 1'b1;
      else case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(9, 0) < 4);
        default: out_stall <= (cyc % 3 == 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    neuron_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (activation_o !== want.act) begin
          $error("activation: expected %0d, got %0d", want.act, activation_o);
          fail_count++;
        end
        if (weight_one_o !== want.w1) begin
          $error("weight_one: expected %0d, got %0d", want.w1, weight_one_o);
          fail_count++;
        end
        if (weight_two_o !== want.w2) begin
          $error("weight_two: expected %0d, got %0d", want.w2, weight_two_o);
          fail_count++;
        end
        if (bias_out_o !== want.b) begin
          $error("bias_out: expected %0d, got %0d", want.b, bias_out_o);
          fail_count++;
        end
        if (batch_done_o !== want.done) begin
          $error("batch_done: expected %0d, got %0d", want.done, batch_done_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
